### src/ptfl_pkg.sv
// shared types and constants for the page translation unit
package ptfl_pkg;
  localparam int KEY_W = 32;
  localparam int TIME_W = 64;
  localparam logic [4:0] MAX_SHIFT = 5'd20;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_SHIFT  = 2'd1,
    REG_FRAMES = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] offset;
    logic        wr;
  } req_t;
endpackage

### src/ptfl_front.sv
// front part: forms key and offset, queues requests for the back part
module ptfl_front import ptfl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  shift,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pid,
  input  logic [31:0] vaddr,
  input  logic        wr,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_data
);
  req_t        slot [2];
  logic        wp, rp;
  logic [1:0]  count;
  logic [31:0] page, mask;
  req_t        req;
  logic        push, pop;

  assign page = vaddr >> shift;
  assign mask = (32'd1 << shift) - 32'd1;
  always_comb begin
    req.key = {pid, 16'd0} | page;
    req.offset = vaddr & mask;
    req.wr = wr;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rp];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= req;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### src/ptfl_back.sv
// back part: scans frames one per cycle, updates table, registers result
module ptfl_back import ptfl_pkg::*; #(
  parameter int FRAME_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        mode,
  input  logic [4:0]  shift,
  input  logic [4:0]  frames_cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] physical_addr,
  output logic        page_hit,
  output logic [3:0]  frame_index,
  output logic        evicted,
  output logic [31:0] evict_key,
  output logic        victim_dirty,
  output logic [31:0] hits_total,
  output logic [31:0] faults_total
);
  localparam int IW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW = $clog2(FRAME_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [FRAME_SLOTS-1:0] used;
  logic [KEY_W-1:0]  key_mem  [FRAME_SLOTS];
  logic              dirty    [FRAME_SLOTS];
  logic [TIME_W-1:0] last_mem [FRAME_SLOTS];
  logic [TIME_W-1:0] load_mem [FRAME_SLOTS];
  logic [TIME_W-1:0] clock_cnt;
  req_t       cur;
  logic [IW-1:0] idx, n_last;
  logic       hit_f, free_f;
  logic [IW-1:0] hit_i, free_i, best_i;
  logic [TIME_W-1:0] best_t, t_cur;
  logic [CW-1:0] n_act;
  logic [4:0] sh;
  // commit and result selection, from the scan plus the last frame
  logic commit;
  logic c_hit, c_free;
  logic [IW-1:0] c_hi, c_fi, c_bi, c_sel;

  always_comb begin
    if (frames_cfg == 5'd0) n_act = CW'(1);
    else if ({27'd0, frames_cfg} > FRAME_SLOTS) n_act = CW'(FRAME_SLOTS);
    else n_act = CW'(frames_cfg);
    n_last = IW'(n_act - CW'(1));
    sh = (shift > MAX_SHIFT) ? MAX_SHIFT : shift;
    t_cur = mode ? last_mem[idx] : load_mem[idx];
  end

  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    c_hit = hit_f; c_hi = hit_i;
    c_free = free_f; c_fi = free_i;
    c_bi = best_i;
    if (used[idx] && key_mem[idx] == cur.key && !hit_f) begin
      c_hit = 1'b1; c_hi = idx;
    end
    if (!used[idx] && !free_f) begin
      c_free = 1'b1; c_fi = idx;
    end
    if (idx == '0 || t_cur < best_t) c_bi = idx;
    c_sel = c_hit ? c_hi : (c_free ? c_fi : c_bi);
    commit = (state == S_SCAN) && (idx == n_last) && !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      clock_cnt <= '0;
      hits_total <= '0;
      faults_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            idx <= '0;
            hit_f <= 1'b0;
            free_f <= 1'b0;
            clock_cnt <= clock_cnt + 64'd1;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (used[idx] && key_mem[idx] == cur.key && !hit_f) begin
            hit_f <= 1'b1;
            hit_i <= idx;
          end
          if (!used[idx] && !free_f) begin
            free_f <= 1'b1;
            free_i <= idx;
          end
          if (idx == '0 || t_cur < best_t) begin
            best_t <= t_cur;
            best_i <= idx;
          end
          if (idx == n_last) state <= S_DONE;
          else idx <= idx + IW'(1);
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        if (c_hit) begin
          hits_total <= hits_total + 32'd1;
        end else begin
          faults_total <= faults_total + 32'd1;
          used[c_sel] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      page_hit <= c_hit;
      frame_index <= 4'(c_sel);
      physical_addr <= (32'(c_sel) << sh) + cur.offset;
      evicted <= !c_hit && !c_free;
      evict_key <= (!c_hit && !c_free) ? key_mem[c_sel] : 32'd0;
      victim_dirty <= (!c_hit && !c_free) ? dirty[c_sel] : 1'b0;
      last_mem[c_sel] <= clock_cnt;
      if (c_hit) begin
        if (cur.wr) dirty[c_sel] <= 1'b1;
      end else begin
        key_mem[c_sel] <= cur.key;
        dirty[c_sel] <= cur.wr;
        load_mem[c_sel] <= clock_cnt;
      end
    end
  end
endmodule

### src/page_translate_fifo_lru_unit.sv
// top level of the page translation unit with fifo or lru replacement
// the frame scan visits one frame per cycle; the scan takes a new transaction only
// after the previous result has been taken, and a 2-entry queue holds requests
// reset clears frame used marks, access clock and counters, and sets config registers to defaults
module page_translate_fifo_lru_unit import ptfl_pkg::*; #(
  parameter int FRAME_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // process_number, virtual_addr, write_access
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // physical_addr, page_hit, frame_index, evicted, evicted key, victim_dirty,
  // hits_total, faults_total
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_data
);
  logic mode;
  logic [4:0] shift, frames;
  logic q_valid, q_ready;
  req_t q_data;
  logic [31:0] pa, vk, ht, ft;
  logic ph, ev, vd;
  logic [3:0] fi;
  logic [4:0] sh;

  assign sh = (shift > MAX_SHIFT) ? MAX_SHIFT : shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      shift <= 5'd12;
      frames <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode <= cfg_data[0];
        REG_SHIFT: shift <= cfg_data;
        REG_FRAMES: frames <= cfg_data;
        default: ;
      endcase
    end
  end

  ptfl_front u_front (
    .clk, .rst, .shift(sh),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .pid(s_axis_tdata[15:0]), .vaddr(s_axis_tdata[47:16]), .wr(s_axis_tdata[48]),
    .q_valid, .q_ready, .q_data
  );

  ptfl_back #(.FRAME_SLOTS(FRAME_SLOTS)) u_back (
    .clk, .rst, .mode, .shift, .frames_cfg(frames),
    .q_valid, .q_ready, .q_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .physical_addr(pa), .page_hit(ph), .frame_index(fi), .evicted(ev),
    .evict_key(vk), .victim_dirty(vd), .hits_total(ht), .faults_total(ft)
  );

  assign m_axis_tdata = {1'b0, ft, ht, vd, vk, ev, fi, ph, pa};
endmodule

### src/ptfl_checker.sv
// port-level checks for the page translation unit
module ptfl_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> !m_axis_tdata[37])
    else $error("hit reported with eviction");
  a_vkey: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[37] |-> m_axis_tdata[69:38] == 32'd0 && !m_axis_tdata[70])
    else $error("victim fields set without eviction");
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
  a_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");
endmodule

bind page_translate_fifo_lru_unit ptfl_checker u_chk (.*);

### dv/testbench.sv
// self-checking testbench for the page translation unit with fifo or lru replacement
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptfl_pkg::*;

  typedef struct packed {
    logic [31:0] faults_total;
    logic [31:0] hits_total;
    logic        victim_dirty;
    logic [31:0] evict_key;
    logic        evicted;
    logic [3:0]  frame_index;
    logic        page_hit;
    logic [31:0] physical_addr;
  } xlat_t;

  class xlat_scoreboard;
    bit          lru_mode;
    logic [4:0]  shift_reg;
    logic [4:0]  frames_reg;
    bit          used [16];
    logic [31:0] key_of [16];
    bit          dirty [16];
    logic [63:0] last_use [16];
    logic [63:0] load_time [16];
    logic [63:0] access_clock;
    logic [31:0] hit_cnt;
    logic [31:0] fault_cnt;
    xlat_t       pending [$];
    int          mismatches;

    function void clear();
      lru_mode = 1'b0;
      shift_reg = 5'd12;
      frames_reg = 5'd16;
      foreach (used[i]) used[i] = 1'b0;
      access_clock = '0;
      hit_cnt = '0;
      fault_cnt = '0;
    endfunction

    function void set_reg(reg_index_t idx, logic [4:0] v);
      case (idx)
        REG_MODE:   lru_mode = v[0];
        REG_SHIFT:  shift_reg = v;
        REG_FRAMES: frames_reg = v;
        default: ;
      endcase
    endfunction

    function void note_access(logic [15:0] pid, logic [31:0] va, logic wr);
      int unsigned sh;
      int unsigned n;
      int          fr;
      logic [31:0] page;
      logic [31:0] offs;
      logic [31:0] k;
      logic [63:0] t;
      logic [63:0] best;
      xlat_t       r;
      sh = (shift_reg > 20) ? 20 : shift_reg;
      n = (frames_reg == 0) ? 1 : (frames_reg > 16 ? 16 : frames_reg);
      page = va >> sh;
      offs = va & ((32'd1 << sh) - 32'd1);
      k = {pid, 16'd0} | page;
      access_clock++;
      r = '0;
      fr = -1;
      for (int i = 0; i < n; i++)
        if (fr < 0 && used[i] && key_of[i] == k) fr = i;
      if (fr >= 0) begin
        r.page_hit = 1'b1;
        hit_cnt++;
        last_use[fr] = access_clock;
        if (wr) dirty[fr] = 1'b1;
      end else begin
        fault_cnt++;
        for (int i = 0; i < n; i++)
          if (fr < 0 && !used[i]) fr = i;
        if (fr < 0) begin
          for (int i = 0; i < n; i++) begin
            t = lru_mode ? last_use[i] : load_time[i];
            if (i == 0 || t < best) begin
              best = t;
              fr = i;
            end
          end
          r.evicted = 1'b1;
          r.evict_key = key_of[fr];
          r.victim_dirty = dirty[fr];
        end
        used[fr] = 1'b1;
        key_of[fr] = k;
        dirty[fr] = wr;
        last_use[fr] = access_clock;
        load_time[fr] = access_clock;
      end
      r.frame_index = fr[3:0];
      r.physical_addr = (32'(fr) << sh) + offs;
      r.hits_total = hit_cnt;
      r.faults_total = fault_cnt;
      pending.push_back(r);
    endfunction

    function void check_result(xlat_t got);
      xlat_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pa=%h hit=%b fr=%0d ev=%b vk=%h vd=%b h=%0d f=%0d",
                   exp_r.physical_addr, exp_r.page_hit, exp_r.frame_index, exp_r.evicted,
                   exp_r.evict_key, exp_r.victim_dirty, exp_r.hits_total,
                   exp_r.faults_total);
        if (mismatches <= 10)
          $display("          actual   pa=%h hit=%b fr=%0d ev=%b vk=%h vd=%b h=%0d f=%0d",
                   got.physical_addr, got.page_hit, got.frame_index, got.evicted,
                   got.evict_key, got.victim_dirty, got.hits_total, got.faults_total);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [4:0]   cfg_data;

  xlat_scoreboard sb;
  bit             quiet;
  bit             hold_off;

  page_translate_fifo_lru_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

  task automatic write_reg(reg_index_t idx, logic [4:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_access(logic [15:0] pid, logic [31:0] va, logic wr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, wr, va, pid};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_access(pid, va, wr);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_phase(int count, int pids, int pages);
    logic [15:0] pid;
    logic [31:0] va;
    int unsigned sh;
    for (int i = 0; i < count; i++) begin
      sh = (sb.shift_reg > 20) ? 20 : sb.shift_reg;
      if ($urandom_range(0, 9) == 0) begin
        pid = 16'($urandom);
        va = $urandom;
      end else begin
        pid = 16'($urandom_range(0, pids - 1));
        va = (32'($urandom_range(0, pages - 1)) << sh) | ($urandom & ((32'd1 << sh) - 1));
      end
      send_access(pid, va, 1'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(xlat_t'(m_axis_tdata[134:0]));
  end

  initial begin
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_axis_tready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fill, hit, dirty evictions, extremes of fields
    write_reg(REG_FRAMES, 5'd2);
    send_access(16'h0000, 32'h0000_0000, 1'b0);
    send_access(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_access(16'h0000, 32'h0000_0FFF, 1'b1);
    send_access(16'h0001, 32'h0000_1000, 1'b0);
    send_access(16'hFFFF, 32'hFFFF_F000, 1'b0);
    send_access(16'h0002, 32'h0000_0000, 1'b1);
    go_idle();
    write_reg(REG_MODE, 5'd1);
    write_reg(REG_SHIFT, 5'd31);
    send_access(16'h0003, 32'h1234_5678, 1'b1);
    send_access(16'h0002, 32'h0000_0000, 1'b0);
    send_access(16'h0004, 32'h8000_0000, 1'b0);
    send_access(16'h0000, 32'h7FFF_FFFF, 1'b1);
    go_idle();
    write_reg(REG_FRAMES, 5'd0);
    write_reg(REG_SHIFT, 5'd0);
    send_access(16'h0001, 32'h0001_0000, 1'b0);
    send_access(16'h0000, 32'hFFFF_0001, 1'b1);
    send_access(16'h0001, 32'h0000_0000, 1'b0);
    go_idle();
    write_reg(REG_FRAMES, 5'd31);
    write_reg(REG_SHIFT, 5'd20);
    send_access(16'h5555, 32'hAAAA_AAAA, 1'b1);
    send_access(16'hAAAA, 32'h5555_5555, 1'b0);
    send_access(16'h0000, 32'h0000_0000, 1'b0);
    go_idle();

    // long receiver stall to fill the input queue
    hold_off = 1;
    random_phase(12, 4, 8);
    go_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, 5'(ph % 2));
      write_reg(REG_SHIFT, (ph % 4 == 0) ? 5'd20 : 5'($urandom_range(0, 31)));
      write_reg(REG_FRAMES, (ph % 4 == 1) ? 5'd1 : 5'($urandom_range(0, 31)));
      if (ph == 7) quiet = 1;
      random_phase(195, $urandom_range(1, 4), $urandom_range(2, 24));
      go_idle();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

### sim.f
src/ptfl_pkg.sv
src/ptfl_front.sv
src/ptfl_back.sv
src/page_translate_fifo_lru_unit.sv
src/ptfl_checker.sv
dv/testbench.sv
